>>> rtl/core/window_stats_tracker_defines.svh
// Assertion macros shared by the window statistics checker.
`ifndef WINDOW_STATS_TRACKER_DEFINES_SVH
`define WINDOW_STATS_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define WST_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define WST_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define WST_ASSERT_NXT_NORST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: reset check failed");

`endif

>>> rtl/core/wst_pkg.sv
// Shared widths, register indexes and controller/datapath interface types.
`default_nettype none

package wst_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 22;
    localparam int DER_W     = 17;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_DEPTH  = 2'd2;

    localparam logic [SAMPLE_W-1:0] MIN_RESET = 16'hFFFF;

    // Ring read address select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_OLD,
        RD_DER,
        RD_INT
    } rd_sel_t;

    // Which holding register takes the ring read data
    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_OLD,
        CAP_DER,
        CAP_INT
    } cap_sel_t;

    // Divider operand select
    typedef enum logic {
        DIV_AVG,
        DIV_DER
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        rd_sel_t  rd_sel;
        cap_sel_t cap_sel;
        logic     commit;
        logic     div_start;
        div_sel_t div_sel;
        logic     avg_load;
        logic     der_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic der_upd;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/wst_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
`default_nettype none

module wst_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [wst_pkg::SUM_W-1:0]  dividend,
    input  wire logic [wst_pkg::CFG_W-1:0]  divisor,
    output logic                            busy,
    output logic      [wst_pkg::SUM_W-1:0]  quotient
);

    localparam int BITS_PER_CYC = 2;
    localparam int DIV_CYC      = (wst_pkg::SUM_W + BITS_PER_CYC - 1) / BITS_PER_CYC;
    localparam int CNT_W        = $clog2(DIV_CYC + 1);

    logic [wst_pkg::SUM_W-1:0] quo_reg, quo_next;
    logic [wst_pkg::CFG_W-1:0] rem_reg, rem_next;
    logic [wst_pkg::CFG_W-1:0] dsr_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic [wst_pkg::CFG_W:0]   trial;

    // Shift dividend bits into the remainder, subtract where it fits
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < BITS_PER_CYC; i++) begin
            trial    = {rem_next, quo_next[wst_pkg::SUM_W-1]};
            quo_next = {quo_next[wst_pkg::SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next    = wst_pkg::CFG_W'(trial - {1'b0, dsr_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial[wst_pkg::CFG_W-1:0];
            end
        end
    end

    // Hold operands and advance one step per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_CYC);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/wst_datapath.sv
// Datapath: config registers, sample ring, running sums, extremes, output register.
`default_nettype none

module wst_datapath #(
    parameter int MAX_DEPTH = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [wst_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [wst_pkg::CFG_W-1:0]       cfg_wr_data,
    input  wire logic [wst_pkg::SAMPLE_W-1:0]    s_sample,
    input  wire wst_pkg::cmd_t                   cmd,
    output wst_pkg::sts_t                        sts,
    output logic      [wst_pkg::SUM_W-1:0]       m_window_sum,
    output logic      [wst_pkg::SAMPLE_W-1:0]    m_average,
    output logic signed [wst_pkg::DER_W-1:0]     m_derivative,
    output logic      [wst_pkg::SUM_W-1:0]       m_integral,
    output logic      [wst_pkg::SAMPLE_W-1:0]    m_max_seen,
    output logic      [wst_pkg::SAMPLE_W-1:0]    m_min_seen
);

    localparam int SW    = wst_pkg::SAMPLE_W;
    localparam int SUMW  = wst_pkg::SUM_W;
    localparam int DW    = wst_pkg::DER_W;
    localparam int CW    = wst_pkg::CFG_W;
    localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > CW) ? CNT_W : CW) + 2;

    // Configuration registers
    logic [CW-1:0] win_depth_reg, der_depth_reg, int_depth_reg;
    logic [CW-1:0] dep, dd, id;

    // Ring storage
    logic [SW-1:0]        ring_mem [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] ring_vld_reg;
    logic [SW-1:0]        rd_data_reg, rd_val;
    logic                 rd_vld_reg;
    logic [PTR_W-1:0]     rd_addr, w, der_slot, int_slot;

    // Item state
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CMP_W-1:0] w_inc;
    logic [CNT_W-1:0] fill_reg, fill_next, fill_p1;
    logic             full;
    logic [SW-1:0]    in_reg, old_reg, der_old_reg, int_old_reg;
    logic [SUMW-1:0]  sum_reg, sum_add, sum_next;
    logic [SUMW-1:0]  integ_reg, int_add, int_sub;
    logic             int_close;
    logic [SUMW-1:0]  hint_reg;
    logic [SW-1:0]    max_reg, min_reg;
    logic [DW-1:0]    held_der_reg;
    logic [SW-1:0]    avg_reg;

    // Divider operands
    logic [CW-1:0]    avg_div_reg, der_div_reg, avg_div_next;
    logic [DW-1:0]    der_mag_reg, der_diff, der_mag, der_q;
    logic             der_neg_reg, der_upd_reg, der_upd_next;
    logic [SUMW-1:0]  div_dividend, div_quo;
    logic [CW-1:0]    div_divisor;
    logic             div_busy;

    // Output register
    logic [SUMW-1:0]  out_sum_reg, out_int_reg;
    logic [SW-1:0]    out_avg_reg, out_max_reg, out_min_reg;
    logic [DW-1:0]    out_der_reg;

    // Slot holding the sample span steps back from slot wv in a ring of dv entries
    function automatic logic [PTR_W-1:0] back_slot(
        input logic [PTR_W-1:0] wv,
        input logic [CW-1:0]    span,
        input logic [CW-1:0]    dv
    );
        logic [CMP_W-1:0] idx;
        idx = CMP_W'(wv) + CMP_W'(dv) - CMP_W'(span);
        if (idx >= CMP_W'(dv)) begin
            idx = idx - CMP_W'(dv);
        end
        return idx[PTR_W-1:0];
    endfunction

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_depth_reg <= CW'(1);
            der_depth_reg <= '0;
            int_depth_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                wst_pkg::CFG_WINDOW_DEPTH: win_depth_reg <= cfg_wr_data;
                wst_pkg::CFG_DERIV_DEPTH:  der_depth_reg <= cfg_wr_data;
                wst_pkg::CFG_INTEG_DEPTH:  int_depth_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Clip depths against the store and the window
    always_comb begin
        if (win_depth_reg != '0 && CMP_W'(win_depth_reg) <= CMP_W'(MAX_DEPTH)) begin
            dep = win_depth_reg;
        end else begin
            dep = CW'(1);
        end
        dd = (der_depth_reg <= dep) ? der_depth_reg : '0;
        id = (int_depth_reg <= dep) ? int_depth_reg : '0;
        w  = (CMP_W'(wp_reg) < CMP_W'(dep)) ? wp_reg : '0;
    end

    assign der_slot = back_slot(w, dd, dep);
    assign int_slot = back_slot(w, id, dep);

    always_comb begin
        unique case (cmd.rd_sel)
            wst_pkg::RD_OLD: rd_addr = w;
            wst_pkg::RD_DER: rd_addr = der_slot;
            wst_pkg::RD_INT: rd_addr = int_slot;
            default:         rd_addr = w;
        endcase
    end

    // Ring: registered read, write on commit
    always_ff @(posedge aclk) begin
        rd_data_reg <= ring_mem[rd_addr];
        if (cmd.commit) begin
            ring_mem[w] <= in_reg;
        end
    end

    // Entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
        end else if (cmd.commit) begin
            ring_vld_reg[w] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rd_vld_reg <= ring_vld_reg[rd_addr];
    end

    assign rd_val = rd_vld_reg ? rd_data_reg : '0;

    // Capture the input beat and the ring reads
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_sample;
        end
        unique case (cmd.cap_sel)
            wst_pkg::CAP_OLD: old_reg     <= rd_val;
            wst_pkg::CAP_DER: der_old_reg <= rd_val;
            wst_pkg::CAP_INT: int_old_reg <= rd_val;
            default: ;
        endcase
    end

    // Commit arithmetic
    always_comb begin
        full      = CMP_W'(fill_reg) >= CMP_W'(dep);
        fill_p1   = fill_reg + CNT_W'(1);
        fill_next = full ? fill_reg : fill_p1;
        sum_add   = sum_reg + SUMW'(in_reg);
        sum_next  = full ? (sum_add - SUMW'(old_reg)) : sum_add;
        avg_div_next = full ? dep : CW'(fill_p1);

        int_add   = integ_reg + SUMW'(in_reg);
        int_sub   = int_add - SUMW'(int_old_reg);
        int_close = CMP_W'(fill_next) >= CMP_W'(id);

        der_upd_next = (dd != '0) && (CMP_W'(fill_reg) >= CMP_W'(dd));
        der_diff     = {1'b0, der_old_reg} - {1'b0, in_reg};
        der_mag      = der_diff[DW-1] ? (DW'(0) - der_diff) : der_diff;

        w_inc   = CMP_W'(w) + CMP_W'(1);
        wp_next = (w_inc >= CMP_W'(dep)) ? '0 : w_inc[PTR_W-1:0];
    end

    // Update window state on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            integ_reg   <= '0;
            hint_reg    <= '0;
            max_reg     <= '0;
            min_reg     <= wst_pkg::MIN_RESET;
            der_upd_reg <= 1'b0;
        end else if (cmd.commit) begin
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            der_upd_reg <= der_upd_next;
            if (id != '0) begin
                integ_reg <= int_close ? int_sub : int_add;
                if (int_close) begin
                    hint_reg <= int_sub;
                end
            end
            if (in_reg > max_reg) begin
                max_reg <= in_reg;
            end
            if (in_reg < min_reg) begin
                min_reg <= in_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            avg_div_reg <= avg_div_next;
            der_div_reg <= dd;
            der_mag_reg <= der_mag;
            der_neg_reg <= der_diff[DW-1];
        end
    end

    // Shared divider: average first, then derivative
    assign div_dividend = (cmd.div_sel == wst_pkg::DIV_AVG) ? sum_reg : SUMW'(der_mag_reg);
    assign div_divisor  = (cmd.div_sel == wst_pkg::DIV_AVG) ? avg_div_reg : der_div_reg;

    wst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign der_q = div_quo[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_der_reg <= '0;
        end else if (cmd.der_load) begin
            held_der_reg <= der_neg_reg ? (DW'(0) - der_q) : der_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.avg_load) begin
            avg_reg <= div_quo[SW-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_sum_reg <= sum_reg;
            out_avg_reg <= avg_reg;
            out_der_reg <= held_der_reg;
            out_int_reg <= hint_reg;
            out_max_reg <= max_reg;
            out_min_reg <= min_reg;
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.der_upd  = der_upd_reg;

    assign m_window_sum = out_sum_reg;
    assign m_average    = out_avg_reg;
    assign m_derivative = $signed(out_der_reg);
    assign m_integral   = out_int_reg;
    assign m_max_seen   = out_max_reg;
    assign m_min_seen   = out_min_reg;

endmodule

`default_nettype wire

>>> rtl/core/wst_ctrl.sv
// Controller: sequences ring reads, commit, divisions and the output beat.
`default_nettype none

module wst_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire wst_pkg::sts_t sts,
    output wst_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OLD,
        S_RD_DER,
        S_RD_INT,
        S_CAP_INT,
        S_COMMIT,
        S_DIV_AVG,
        S_WAIT_AVG,
        S_DIV_DER,
        S_WAIT_DER,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd.load_in   = 1'b0;
        cmd.rd_sel    = wst_pkg::RD_NONE;
        cmd.cap_sel   = wst_pkg::CAP_NONE;
        cmd.commit    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = wst_pkg::DIV_AVG;
        cmd.avg_load  = 1'b0;
        cmd.der_load  = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_RD_OLD;
                end
            end
            S_RD_OLD: begin
                cmd.rd_sel = wst_pkg::RD_OLD;
                state_next = S_RD_DER;
            end
            S_RD_DER: begin
                cmd.rd_sel  = wst_pkg::RD_DER;
                cmd.cap_sel = wst_pkg::CAP_OLD;
                state_next  = S_RD_INT;
            end
            S_RD_INT: begin
                cmd.rd_sel  = wst_pkg::RD_INT;
                cmd.cap_sel = wst_pkg::CAP_DER;
                state_next  = S_CAP_INT;
            end
            S_CAP_INT: begin
                cmd.cap_sel = wst_pkg::CAP_INT;
                state_next  = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DIV_AVG;
            end
            S_DIV_AVG: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = wst_pkg::DIV_AVG;
                state_next    = S_WAIT_AVG;
            end
            S_WAIT_AVG: begin
                if (!sts.div_busy) begin
                    cmd.avg_load = 1'b1;
                    state_next   = sts.der_upd ? S_DIV_DER : S_OUT;
                end
            end
            S_DIV_DER: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = wst_pkg::DIV_DER;
                state_next    = S_WAIT_DER;
            end
            S_WAIT_DER: begin
                cmd.div_sel = wst_pkg::DIV_DER;
                if (!sts.div_busy) begin
                    cmd.der_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/window_stats_tracker.sv
// Moving-window statistics top level: controller plus datapath.
//
// Each sample beat enters a ring of up to MAX_DEPTH entries and yields one result
// beat: window sum, truncated average, held derivative, held integral and the
// maximum and minimum since reset. The time from accept to result is set by the
// ring's single read port (three reads per sample) and by one shared divider
// retiring two quotient bits per cycle, run once for the average and, when the
// derivative updates, once more for the derivative. The next sample is taken
// once the result sits in the output register, even if it has not been taken
// yet. The ring reads as zero until written, through per-entry valid bits, so
// no clearing pass runs after reset. Configuration writes are taken at any time
// but belong to idle periods.
`default_nettype none

module window_stats_tracker #(
    parameter int MAX_DEPTH = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [wst_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [wst_pkg::CFG_W-1:0]       cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [wst_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [wst_pkg::SUM_W-1:0]       m_window_sum,
    output logic      [wst_pkg::SAMPLE_W-1:0]    m_average,
    output logic signed [wst_pkg::DER_W-1:0]     m_derivative,
    output logic      [wst_pkg::SUM_W-1:0]       m_integral,
    output logic      [wst_pkg::SAMPLE_W-1:0]    m_max_seen,
    output logic      [wst_pkg::SAMPLE_W-1:0]    m_min_seen
);

    wst_pkg::cmd_t cmd;
    wst_pkg::sts_t sts;

    wst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wst_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_sample     (s_sample),
        .cmd          (cmd),
        .sts          (sts),
        .m_window_sum (m_window_sum),
        .m_average    (m_average),
        .m_derivative (m_derivative),
        .m_integral   (m_integral),
        .m_max_seen   (m_max_seen),
        .m_min_seen   (m_min_seen)
    );

endmodule

`default_nettype wire

>>> rtl/core/wst_checker.sv
// Port-level checker for the window statistics block, bound to the top level.
`default_nettype none

`include "window_stats_tracker_defines.svh"

module wst_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic      [wst_pkg::SUM_W-1:0]    m_window_sum,
    input wire logic      [wst_pkg::SAMPLE_W-1:0] m_average,
    input wire logic signed [wst_pkg::DER_W-1:0]  m_derivative,
    input wire logic      [wst_pkg::SAMPLE_W-1:0] m_max_seen,
    input wire logic      [wst_pkg::SAMPLE_W-1:0] m_min_seen
);

    // Reset leaves no result pending and the input open
    `WST_ASSERT_NXT_NORST(a_reset_idle, aclk, !aresetn, !m_valid && s_ready)

    // One sample in flight: input closes right after a beat is taken
    `WST_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // Every result follows at least one sample, so the extremes are ordered
    `WST_ASSERT_IMP(a_max_ge_min, aclk, aresetn, m_valid, m_max_seen >= m_min_seen)

    // A stalled result beat holds
    `WST_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_window_sum) && $stable(m_average) && $stable(m_derivative))

endmodule

bind window_stats_tracker wst_checker u_wst_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_window_sum (m_window_sum),
    .m_average    (m_average),
    .m_derivative (m_derivative),
    .m_max_seen   (m_max_seen),
    .m_min_seen   (m_min_seen)
);

`default_nettype wire
